@@ rtl/evq_pkg.sv @@
package evq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned PAYLOAD_DEF = 32;
  localparam int unsigned COUNT_DEF   = 32;
  localparam int unsigned CAP_BITS    = 5;

  typedef enum logic [2:0] {
    REQ_ENQ   = 3'd0,
    REQ_DEQ   = 3'd1,
    REQ_PURGE = 3'd2,
    REQ_CLR   = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    POL_DROP_NEW = 2'd0,
    POL_DROP_LOW = 2'd1,
    POL_BLOCK    = 2'd2,
    POL_INVALID  = 2'd3
  } pol_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_INVAL = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

@@ rtl/evq_in_if.sv @@
interface evq_in_if #(
  parameter int unsigned PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              req_type;
  logic [1:0]              overflow_policy;
  logic [7:0]              in_type;
  logic [7:0]              in_priority;
  logic [PAYLOAD_BITS-1:0] in_payload;

  modport source (output valid, req_type, overflow_policy, in_type, in_priority, in_payload,
                  input ready);
  modport sink (input valid, req_type, overflow_policy, in_type, in_priority, in_payload,
                output ready);
endinterface

@@ rtl/evq_out_if.sv @@
interface evq_out_if #(
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned COUNT_BITS   = 32,
  parameter int unsigned DEPTH_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [7:0]              out_type;
  logic [7:0]              out_priority;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [DEPTH_BITS-1:0]   depth_now;
  logic                    is_full;
  logic                    is_empty;
  logic [COUNT_BITS-1:0]   enqueue_total;
  logic [COUNT_BITS-1:0]   dequeue_total;
  logic [COUNT_BITS-1:0]   overflow_total;
  logic [COUNT_BITS-1:0]   drop_total;
  logic [DEPTH_BITS-1:0]   peak_depth;

  modport source (output valid, status, out_type, out_priority, out_payload, depth_now,
                  is_full, is_empty, enqueue_total, dequeue_total, overflow_total,
                  drop_total, peak_depth, input ready);
  modport sink (input valid, status, out_type, out_priority, out_payload, depth_now,
                is_full, is_empty, enqueue_total, dequeue_total, overflow_total,
                drop_total, peak_depth, output ready);
endinterface

@@ rtl/event_fifo_with_priority_eviction_top.sv @@
// a request is taken in S_IDLE, executed in S_EXEC and held in S_DONE until the result register is free
// a full enqueue under drop-lowest first scans with one memory read per entry to find the
// worst one, then, if the new event is kept, shifts with one read and write per entry to close the gap
// one request in flight at a time; the result register lets the next request in early
// reset: queue empty, counters and watermark zero, capacity DEPTH; no clearing pass
module event_fifo_with_priority_eviction_top #(
  parameter int unsigned DEPTH        = evq_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = evq_pkg::PAYLOAD_DEF,
  parameter int unsigned COUNT_BITS   = evq_pkg::COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          capacity_in_use_we_i,
  input  logic [evq_pkg::CAP_BITS-1:0]  capacity_in_use_i,
  evq_in_if.sink                        in_i,
  evq_out_if.source                     out_o
);
  import evq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = 16 + PAYLOAD_BITS;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW:0] i);
    logic [CW+1:0] s;
    s = (CW+2)'(h) + (CW+2)'(i);
    if (s >= (CW+2)'(DEPTH)) s = s - (CW+2)'(DEPTH);
    return AW'(s);
  endfunction

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_e state_q, state_d;
  logic [CAP_BITS-1:0] cap_q;
  logic [CW-1:0] eff_cap;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d, wm_q, wm_d;
  logic [COUNT_BITS-1:0] enq_q, enq_d, deq_q, deq_d, ovf_q, ovf_d, drop_q, drop_d;
  logic [CW-1:0] idx_q, idx_d, worst_q, worst_d;
  logic [7:0] worst_prio_q, worst_prio_d;

  logic [2:0] req_q;
  logic [1:0] pol_q;
  logic [7:0] typ_q, prio_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic [1:0] res_st_q, res_st_d;
  logic [EW-1:0] res_ev_q, res_ev_d;

  logic in_xfer, out_free, out_load, ovalid_q;

  assign eff_cap = (cap_q == '0) ? CW'(1) :
                   (int'(cap_q) > int'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign out_load   = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_BITS'(DEPTH);
    end else if (capacity_in_use_we_i) begin
      cap_q <= capacity_in_use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= in_i.req_type;
      pol_q  <= in_i.overflow_policy;
      typ_q  <= in_i.in_type;
      prio_q <= in_i.in_priority;
      pay_q  <= in_i.in_payload;
    end
    res_st_q     <= res_st_d;
    res_ev_q     <= res_ev_d;
    idx_q        <= idx_d;
    worst_q      <= worst_d;
    worst_prio_q <= worst_prio_d;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    wm_d         = wm_q;
    enq_d        = enq_q;
    deq_d        = deq_q;
    ovf_d        = ovf_q;
    drop_d       = drop_q;
    idx_d        = idx_q;
    worst_d      = worst_q;
    worst_prio_d = worst_prio_q;
    res_st_d     = res_st_q;
    res_ev_d     = res_ev_q;
    rd_addr      = head_q;
    wr_en        = 1'b0;
    wr_addr      = phys(head_q, (CW+1)'(fill_q));
    wr_data      = {typ_q, prio_q, pay_q};
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        res_st_d = ST_OK;
        res_ev_d = '0;
        state_d  = S_DONE;
        case (req_q)
          REQ_ENQ: begin
            if (fill_q < eff_cap) begin
              wr_en  = 1'b1;
              fill_d = fill_q + CW'(1);
              enq_d  = enq_q + COUNT_BITS'(1);
              if (fill_d > wm_q) wm_d = fill_d;
            end else begin
              ovf_d = ovf_q + COUNT_BITS'(1);
              case (pol_q)
                POL_DROP_NEW, POL_BLOCK: res_st_d = ST_FULL;
                POL_DROP_LOW: begin
                  worst_d      = '0;
                  worst_prio_d = rd_data_q[PAYLOAD_BITS +: 8];
                  idx_d        = CW'(1);
                  rd_addr      = phys(head_q, (CW+1)'(1));
                  state_d      = S_SCAN;
                end
                default: res_st_d = ST_INVAL;
              endcase
            end
          end
          REQ_DEQ: begin
            if (fill_q == '0) begin
              res_st_d = ST_EMPTY;
            end else begin
              res_ev_d = rd_data_q;
              head_d   = phys(head_q, (CW+1)'(1));
              fill_d   = fill_q - CW'(1);
              deq_d    = deq_q + COUNT_BITS'(1);
            end
          end
          REQ_PURGE: begin
            drop_d = drop_q + COUNT_BITS'(fill_q);
            fill_d = '0;
          end
          REQ_CLR: begin
            enq_d  = '0;
            deq_d  = '0;
            ovf_d  = '0;
            drop_d = '0;
            wm_d   = '0;
          end
          REQ_QUERY: ;
          default: res_st_d = ST_INVAL;
        endcase
      end
      S_SCAN: begin
        if (idx_q < fill_q) begin
          if (rd_data_q[PAYLOAD_BITS +: 8] > worst_prio_q) begin
            worst_d      = idx_q;
            worst_prio_d = rd_data_q[PAYLOAD_BITS +: 8];
          end
          idx_d   = idx_q + CW'(1);
          rd_addr = phys(head_q, (CW+1)'(idx_q) + (CW+1)'(1));
        end else begin
          drop_d = drop_q + COUNT_BITS'(1);
          if (prio_q > worst_prio_q) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            enq_d   = enq_q + COUNT_BITS'(1);
            idx_d   = worst_q;
            rd_addr = phys(head_q, (CW+1)'(worst_q) + (CW+1)'(1));
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, (CW+1)'(idx_q));
        if ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(fill_q)) begin
          wr_data = rd_data_q;
          idx_d   = idx_q + CW'(1);
          rd_addr = phys(head_q, (CW+1)'(idx_q) + (CW+1)'(2));
        end else begin
          if (fill_q > wm_q) wm_d = fill_q;
          res_st_d = ST_OK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      wm_q     <= '0;
      enq_q    <= '0;
      deq_q    <= '0;
      ovf_q    <= '0;
      drop_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      wm_q    <= wm_d;
      enq_q   <= enq_d;
      deq_q   <= deq_d;
      ovf_q   <= ovf_d;
      drop_q  <= drop_d;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.status         <= res_st_q;
      out_o.out_type       <= res_ev_q[PAYLOAD_BITS+8 +: 8];
      out_o.out_priority   <= res_ev_q[PAYLOAD_BITS +: 8];
      out_o.out_payload    <= res_ev_q[PAYLOAD_BITS-1:0];
      out_o.depth_now      <= fill_q;
      out_o.is_full        <= (fill_q >= eff_cap);
      out_o.is_empty       <= (fill_q == '0);
      out_o.enqueue_total  <= enq_q;
      out_o.dequeue_total  <= deq_q;
      out_o.overflow_total <= ovf_q;
      out_o.drop_total     <= drop_q;
      out_o.peak_depth     <= wm_q;
    end
  end

  assign out_o.valid = ovalid_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH)) else $error("fill count beyond depth");

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_evict_only_enq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> (req_q == REQ_ENQ && pol_q == POL_DROP_LOW))
    else $error("eviction without drop-lowest enqueue");

  a_evict_keeps_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> $stable(fill_q)) else $error("eviction changed fill count");

endmodule

@@ test/tb.sv @@
module tb;
  import evq_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned LIMIT    = 20000;
  localparam int unsigned N_RANDOM = 1530;

  typedef struct packed {
    logic [2:0]  req;
    logic [1:0]  pol;
    logic [7:0]  typ;
    logic [7:0]  prio;
    logic [31:0] pay;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  typ;
    logic [7:0]  prio;
    logic [31:0] pay;
    logic [4:0]  depth;
    logic        full;
    logic        empty;
    logic [31:0] enq_tot;
    logic [31:0] deq_tot;
    logic [31:0] ovf_tot;
    logic [31:0] drop_tot;
    logic [4:0]  peak;
  } answer_t;

  // one directed row: the request and, where obvious, its expected status and depth
  typedef struct packed {
    request_t   rq;
    logic       known;
    logic [1:0] status;
    logic [4:0] depth;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cap_we;
  logic [4:0] cap_val;

  evq_in_if  #(.PAYLOAD_BITS(32)) in_bus ();
  evq_out_if #(.PAYLOAD_BITS(32), .COUNT_BITS(32), .DEPTH_BITS(5)) out_bus ();

  event_fifo_with_priority_eviction_top #(.DEPTH(DEPTH)) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .capacity_in_use_we_i (cap_we),
    .capacity_in_use_i    (cap_val),
    .in_i                 (in_bus),
    .out_o                (out_bus)
  );

  // model state
  logic [7:0]  q_type [DEPTH];
  logic [7:0]  q_prio [DEPTH];
  logic [31:0] q_pay  [DEPTH];
  int unsigned q_fill;
  logic [31:0] n_enq, n_deq, n_ovf, n_drop;
  logic [4:0]  q_peak;
  logic [4:0]  q_cap;

  answer_t     pending_answers[$];
  row_t        pending_rows[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  bit          fifo_bias;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_limit();
    if (q_cap == 0) return 1;
    if (q_cap > DEPTH) return DEPTH;
    return q_cap;
  endfunction

  function automatic void drop_slot(int unsigned k);
    for (int unsigned i = k; i + 1 < q_fill; i++) begin
      q_type[i] = q_type[i + 1];
      q_prio[i] = q_prio[i + 1];
      q_pay[i]  = q_pay[i + 1];
    end
    if (q_fill > 0) q_fill--;
  endfunction

  function automatic void append_event(request_t rq);
    q_type[q_fill] = rq.typ;
    q_prio[q_fill] = rq.prio;
    q_pay[q_fill]  = rq.pay;
    q_fill++;
    n_enq++;
    if (q_fill > q_peak) q_peak = 5'(q_fill);
  endfunction

  function automatic answer_t predict_queue(request_t rq);
    answer_t     a;
    int unsigned worst;
    a = '0;
    a.status = ST_OK;
    case (rq.req)
      REQ_ENQ: begin
        if (q_fill < cap_limit()) begin
          append_event(rq);
        end else begin
          n_ovf++;
          if (rq.pol == POL_DROP_NEW || rq.pol == POL_BLOCK) begin
            a.status = ST_FULL;
          end else if (rq.pol == POL_INVALID) begin
            a.status = ST_INVAL;
          end else begin
            worst = 0;
            for (int unsigned i = 1; i < q_fill; i++)
              if (q_prio[i] > q_prio[worst]) worst = i;
            n_drop++;
            if (rq.prio > q_prio[worst]) begin
              a.status = ST_FULL;
            end else begin
              drop_slot(worst);
              append_event(rq);
            end
          end
        end
      end
      REQ_DEQ: begin
        if (q_fill == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.typ  = q_type[0];
          a.prio = q_prio[0];
          a.pay  = q_pay[0];
          drop_slot(0);
          n_deq++;
        end
      end
      REQ_PURGE: begin
        n_drop += q_fill;
        q_fill = 0;
      end
      REQ_CLR: begin
        n_enq = '0;
        n_deq = '0;
        n_ovf = '0;
        n_drop = '0;
        q_peak = '0;
      end
      REQ_QUERY: ;
      default: a.status = ST_INVAL;
    endcase
    a.depth    = 5'(q_fill);
    a.full     = q_fill >= cap_limit();
    a.empty    = q_fill == 0;
    a.enq_tot  = n_enq;
    a.deq_tot  = n_deq;
    a.ovf_tot  = n_ovf;
    a.drop_tot = n_drop;
    a.peak     = q_peak;
    return a;
  endfunction

  // sender
  task automatic send_request(request_t rq, row_t row);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.req_type        <= rq.req;
    in_bus.overflow_policy <= rq.pol;
    in_bus.in_type         <= rq.typ;
    in_bus.in_priority     <= rq.prio;
    in_bus.in_payload      <= rq.pay;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_answers.push_back(predict_queue(rq));
    pending_rows.push_back(row);
  endtask

  task automatic send_plain(request_t rq);
    send_request(rq, '0);
  endtask

  task automatic drain_and_write(logic [4:0] cap);
    in_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);
    cap_we  <= 1'b1;
    cap_val <= cap;
    @(posedge clk_i);
    cap_we <= 1'b0;
    q_cap = cap;
  endtask

  function automatic request_t random_request();
    request_t    rq;
    int unsigned r;
    rq.typ  = 8'($urandom);
    rq.prio = 8'($urandom);
    rq.pay  = $urandom;
    rq.pol  = 2'($urandom_range(3, 0));
    r = $urandom_range(99, 0);
    if (r < 2)       rq.req = 3'($urandom_range(7, 5));
    else if (r < 5)  rq.req = REQ_PURGE;
    else if (r < 7)  rq.req = REQ_CLR;
    else if (r < 11) rq.req = REQ_QUERY;
    else if (r < (fifo_bias ? 70 : 45)) rq.req = REQ_ENQ;
    else rq.req = REQ_DEQ;
    if ($urandom_range(3, 0) != 0) rq.pol = POL_DROP_LOW;
    return rq;
  endfunction

  // receiver and checker
  initial begin
    answer_t a;
    answer_t g;
    row_t    row;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        g = '{out_bus.status, out_bus.out_type, out_bus.out_priority, out_bus.out_payload,
              out_bus.depth_now, out_bus.is_full, out_bus.is_empty, out_bus.enqueue_total,
              out_bus.dequeue_total, out_bus.overflow_total, out_bus.drop_total,
              out_bus.peak_depth};
        if (pending_answers.size() == 0) begin
          $error("result with nothing outstanding");
          errors++;
        end else begin
          a   = pending_answers.pop_front();
          row = pending_rows.pop_front();
          if (row.known && (row.status != a.status || row.depth != a.depth)) begin
            $error("table row disagrees: status %0d depth %0d", row.status, row.depth);
            errors++;
          end
          if (g.status !== a.status) begin
            $error("status exp %0d got %0d", a.status, g.status); errors++;
          end
          if (g.typ !== a.typ) begin
            $error("out_type exp %0h got %0h", a.typ, g.typ); errors++;
          end
          if (g.prio !== a.prio) begin
            $error("out_priority exp %0h got %0h", a.prio, g.prio); errors++;
          end
          if (g.pay !== a.pay) begin
            $error("out_payload exp %0h got %0h", a.pay, g.pay); errors++;
          end
          if (g.depth !== a.depth) begin
            $error("depth_now exp %0d got %0d", a.depth, g.depth); errors++;
          end
          if (g.full !== a.full) begin
            $error("is_full exp %0b got %0b", a.full, g.full); errors++;
          end
          if (g.empty !== a.empty) begin
            $error("is_empty exp %0b got %0b", a.empty, g.empty); errors++;
          end
          if (g.enq_tot !== a.enq_tot) begin
            $error("enqueue_total exp %0d got %0d", a.enq_tot, g.enq_tot); errors++;
          end
          if (g.deq_tot !== a.deq_tot) begin
            $error("dequeue_total exp %0d got %0d", a.deq_tot, g.deq_tot); errors++;
          end
          if (g.ovf_tot !== a.ovf_tot) begin
            $error("overflow_total exp %0d got %0d", a.ovf_tot, g.ovf_tot); errors++;
          end
          if (g.drop_tot !== a.drop_tot) begin
            $error("drop_total exp %0d got %0d", a.drop_tot, g.drop_tot); errors++;
          end
          if (g.peak !== a.peak) begin
            $error("peak_depth exp %0d got %0d", a.peak, g.peak); errors++;
          end
        end
      end
      out_bus.ready <= !hold_off &&
                       !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // long hold-off, counted here so the block fills and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (fifo_bias);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("event_fifo_with_priority_eviction_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    row_t     rows[$];
    request_t rq;
    int unsigned n;
    errors = 0;
    q_fill = 0;
    n_enq = '0; n_deq = '0; n_ovf = '0; n_drop = '0; q_peak = '0;
    q_cap = 5'(DEPTH);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fifo_bias = 1'b0;
    rst_ni = 1'b0;
    cap_we = 1'b0;
    cap_val = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_QUERY;
    in_bus.overflow_policy = POL_DROP_NEW;
    in_bus.in_type = '0;
    in_bus.in_priority = '0;
    in_bus.in_payload = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capacity two: fill, overflow under each policy, evictions and ties
    drain_and_write(5'd2);
    rows = '{
      '{'{REQ_DEQ,   POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_EMPTY, 5'd0},
      '{'{REQ_QUERY, POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_OK,    5'd0},
      '{'{REQ_ENQ,   POL_INVALID,  8'hff, 8'hff, 32'hffffffff}, 1'b1, ST_OK,    5'd1},
      '{'{REQ_ENQ,   POL_DROP_NEW, 8'h00, 8'hff, 32'h0},        1'b1, ST_OK,    5'd2},
      '{'{REQ_ENQ,   POL_DROP_NEW, 8'h11, 8'h01, 32'h1},        1'b1, ST_FULL,  5'd2},
      '{'{REQ_ENQ,   POL_BLOCK,    8'h12, 8'h01, 32'h2},        1'b1, ST_FULL,  5'd2},
      '{'{REQ_ENQ,   POL_INVALID,  8'h13, 8'h01, 32'h3},        1'b1, ST_INVAL, 5'd2},
      '{'{REQ_ENQ,   POL_DROP_LOW, 8'h14, 8'hff, 32'h4},        1'b1, ST_OK,    5'd2},
      '{'{REQ_ENQ,   POL_DROP_LOW, 8'h15, 8'h00, 32'h5},        1'b1, ST_OK,    5'd2},
      '{'{REQ_ENQ,   POL_DROP_LOW, 8'h16, 8'h80, 32'h6},        1'b1, ST_OK,    5'd2},
      '{'{REQ_ENQ,   POL_DROP_LOW, 8'h17, 8'hff, 32'h7},        1'b1, ST_FULL,  5'd2},
      '{'{REQ_DEQ,   POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b0, ST_OK,    5'd1},
      '{'{3'd5,      POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_INVAL, 5'd1},
      '{'{3'd7,      POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_INVAL, 5'd1},
      '{'{REQ_ENQ,   POL_DROP_NEW, 8'haa, 8'h55, 32'h5555aaaa}, 1'b1, ST_OK,    5'd2},
      '{'{REQ_PURGE, POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_OK,    5'd0},
      '{'{REQ_CLR,   POL_DROP_NEW, 8'h00, 8'h00, 32'h0},        1'b1, ST_OK,    5'd0},
      '{'{REQ_ENQ,   POL_DROP_NEW, 8'h55, 8'haa, 32'haaaa5555}, 1'b1, ST_OK,    5'd1},
      '{'{REQ_ENQ,   POL_DROP_NEW, 8'h01, 8'haa, 32'h8},        1'b1, ST_OK,    5'd2}
    };
    foreach (rows[i]) send_request(rows[i].rq, rows[i]);

    // capacity lowered below depth, then the out-of-range values zero and 31
    drain_and_write(5'd1);
    send_request('{REQ_ENQ, POL_DROP_LOW, 8'h02, 8'haa, 32'h9}, '0);
    send_request('{REQ_QUERY, POL_DROP_NEW, 8'h0, 8'h0, 32'h0}, '0);
    drain_and_write(5'd0);
    send_request('{REQ_DEQ, POL_DROP_NEW, 8'h0, 8'h0, 32'h0}, '0);
    send_request('{REQ_ENQ, POL_BLOCK, 8'h03, 8'h03, 32'h3}, '0);
    drain_and_write(5'd31);
    send_request('{REQ_QUERY, POL_DROP_NEW, 8'h0, 8'h0, 32'h0}, '0);

    // random phases over capacities and idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: drain_and_write(5'd16);
        1: drain_and_write(5'd4);
        2: drain_and_write(5'd16);
        3: drain_and_write(5'd1);
        4: drain_and_write(5'($urandom_range(16, 2)));
        default: drain_and_write(5'd16);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      fifo_bias = (phase >= 2);
      n = N_RANDOM / 6;
      repeat (n) begin
        rq = random_request();
        send_plain(rq);
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);
    if (errors == 0)
      $display("event_fifo_with_priority_eviction_top: match");
    else
      $display("event_fifo_with_priority_eviction_top: mismatch");
    $finish;
  end
endmodule
